FILE: rtl/wmsc_pkg.sv
// ----------------------------------------------------------------------------
// Windowed minimum SAD cost package
// Shared types, constants and helpers for the plane-sweep matching cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmsc_pkg;

  localparam int WIN_R      = 2;
  localparam int WIN        = 2 * WIN_R + 1;
  localparam int TSLOTS     = 2 * WIN_R + 2;
  localparam int SLOT_BITS  = 3;
  localparam int BANK_BITS  = 3;
  localparam int CH_BITS    = 8;
  localparam int COST_BITS  = 10;
  localparam int COL_BITS   = 11;
  localparam int WIDTH_BITS = 12;
  localparam int HRAW_BITS  = 11;
  localparam int MAX_WIDTH  = 2048;
  localparam int IDX_BITS   = 2;
  localparam int DATA_BITS  = 12;

  localparam logic [COST_BITS-1:0] NO_MATCH = 10'd1023;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_FRAME_HEIGHT = 2'd0,
    REG_FRAME_WIDTH  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic ok;
    pix_t pix;
  } tmpl_t;

  typedef struct packed {
    logic                 ok;
    pix_t                 pix;
    logic [COST_BITS-1:0] prior;
  } ref_t;

  typedef struct packed {
    logic                 en;
    logic [SLOT_BITS-1:0] slot;
    logic [BANK_BITS-1:0] bank;
  } tmpl_wr_t;

  function automatic logic [CH_BITS-1:0] absdiff(input logic [CH_BITS-1:0] a,
                                                 input logic [CH_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [COST_BITS-1:0] sad(input pix_t a, input pix_t b);
    return COST_BITS'(absdiff(a.red, b.red)) + COST_BITS'(absdiff(a.green, b.green))
         + COST_BITS'(absdiff(a.blue, b.blue));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wmsc_ifs.sv
// ----------------------------------------------------------------------------
// Windowed minimum SAD cost channels
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmsc_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [wmsc_pkg::CH_BITS-1:0] ref_red;
  logic [wmsc_pkg::CH_BITS-1:0] ref_green;
  logic [wmsc_pkg::CH_BITS-1:0] ref_blue;
  logic                         ref_valid;
  logic [wmsc_pkg::CH_BITS-1:0] tmpl_red;
  logic [wmsc_pkg::CH_BITS-1:0] tmpl_green;
  logic [wmsc_pkg::CH_BITS-1:0] tmpl_blue;
  logic                         tmpl_valid;
  logic [wmsc_pkg::COST_BITS-1:0] prior_cost;

  modport source (output valid, op, ref_red, ref_green, ref_blue, ref_valid,
                  tmpl_red, tmpl_green, tmpl_blue, tmpl_valid, prior_cost,
                  input ready);
  modport sink (input valid, op, ref_red, ref_green, ref_blue, ref_valid,
                tmpl_red, tmpl_green, tmpl_blue, tmpl_valid, prior_cost,
                output ready);
endinterface

interface wmsc_res_if;
  logic                           valid;
  logic                           ready;
  logic [wmsc_pkg::COST_BITS-1:0] cost;
  logic                           frame_end;

  modport source (output valid, cost, frame_end, input ready);
  modport sink (input valid, cost, frame_end, output ready);
endinterface

interface wmsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wmsc_pkg::IDX_BITS-1:0]  index;
  logic [wmsc_pkg::DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/wmsc_tmpl_store.sv
// ----------------------------------------------------------------------------
// Template column store
// One bank per column slot and row residue, so a whole window reads at once.
// ----------------------------------------------------------------------------
`default_nettype none

module wmsc_tmpl_store #(
  parameter int MAX_HEIGHT = 1024,
  localparam int BANK_DEPTH = (MAX_HEIGHT + wmsc_pkg::WIN - 1) / wmsc_pkg::WIN,
  localparam int AB = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic               clk,
  input  wmsc_pkg::tmpl_wr_t wr,
  input  logic [AB-1:0]      wr_addr,
  input  wmsc_pkg::tmpl_t    wr_data,
  input  logic               rd_en,
  input  logic [AB-1:0]      rd_addr [wmsc_pkg::WIN],
  output wmsc_pkg::tmpl_t    rd_data [wmsc_pkg::TSLOTS][wmsc_pkg::WIN]
);

  for (genvar s = 0; s < wmsc_pkg::TSLOTS; s++) begin : g_slot
    for (genvar b = 0; b < wmsc_pkg::WIN; b++) begin : g_bank
      wmsc_pkg::tmpl_t mem [BANK_DEPTH];

      always_ff @(posedge clk) begin
        if (wr.en && wr.slot == wmsc_pkg::SLOT_BITS'(s)
            && wr.bank == wmsc_pkg::BANK_BITS'(b)) begin
          mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
          rd_data[s][b] <= mem[rd_addr[b]];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/window_min_sad_cost_unit.sv
// ----------------------------------------------------------------------------
// Windowed minimum SAD cost unit
// Plane-sweep stereo matching cost over a 5x5 template window, column-major.
// ----------------------------------------------------------------------------
// Each result passes stage 1, 2, 3 and the output register; back-pressure can stall it.
// Throughput: one item per cycle unless stalled; banks read a full window per cycle.
// Results trail pixels by 2*H + min(2, H-1) positions; flush items drain the rest.
// Reset (synchronous, active high) clears counters and pipeline valids; height and
// width return to min(1024, MAX_HEIGHT) and 1024. Store contents are not cleared.
`default_nettype none

module window_min_sad_cost_unit #(
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  wmsc_pix_if.sink    pixels,
  wmsc_res_if.source  results,
  wmsc_cfg_if.sink    cfg
);

  localparam int WIN    = wmsc_pkg::WIN;
  localparam int TS     = wmsc_pkg::TSLOTS;
  localparam int SB     = wmsc_pkg::SLOT_BITS;
  localparam int BB     = wmsc_pkg::BANK_BITS;
  localparam int CB     = wmsc_pkg::COL_BITS;
  localparam int WB     = wmsc_pkg::WIDTH_BITS;
  localparam int KB     = wmsc_pkg::COST_BITS;
  localparam int HB     = $clog2(MAX_HEIGHT + 1);
  localparam int RB     = $clog2(MAX_HEIGHT);
  localparam int BANK_DEPTH = (MAX_HEIGHT + WIN - 1) / WIN;
  localparam int AB     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int RDEPTH = wmsc_pkg::WIN_R * MAX_HEIGHT + wmsc_pkg::WIN_R + 1;
  localparam int PB     = $clog2(RDEPTH);
  localparam int NB     = $clog2(RDEPTH + 1);
  localparam int RESET_H = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int RESET_DLY = 2 * RESET_H + ((RESET_H - 1 < 2) ? RESET_H - 1 : 2);

  // Frame geometry.
  logic [HB-1:0] h;
  logic [WB-1:0] w;
  logic [NB-1:0] dly;
  logic [HB-1:0] h_next;
  logic [WB-1:0] w_next;
  logic [NB-1:0] dly_next;
  logic [12:0]   hraw;

  // Position counters.
  logic [RB-1:0] irow, y;
  logic [BB-1:0] imod, ymod;
  logic [AB-1:0] idiv, ydiv;
  logic [CB-1:0] icol, x;
  logic [SB-1:0] islot, xs;
  logic          frame_received;
  logic [NB-1:0] pend, pend_after;
  logic [PB-1:0] wrp, rdp;

  logic acc, is_write, emit, cfg_acc, cfg_hit, in_last, out_last;

  // Pipeline control.
  logic s1_valid, s2_valid, s3_valid, o_valid;
  logic s1_ready, s2_ready, s3_ready, o_adv;

  // Window addressing.
  logic [BB-1:0] bank_k [WIN];
  logic [AB-1:0] addr_k [WIN];
  logic [AB-1:0] rd_addr [WIN];
  logic [SB-1:0] slot_j [WIN];
  logic [3:0]    rsum;
  logic [3:0]    bsum;
  logic [3:0]    ssum;
  logic [WIN-1:0] ok_k [WIN];
  logic [WIN-1:0] fwd_k [WIN];
  logic [NB+1:0] hterm;

  wmsc_pkg::tmpl_wr_t tw;
  wmsc_pkg::tmpl_t    tw_data;
  wmsc_pkg::tmpl_t    rdata [TS][WIN];
  wmsc_pkg::ref_t     rmem [RDEPTH];
  wmsc_pkg::ref_t     ref_rd;

  // Stage 1.
  logic [WIN-1:0]  s1_ok [WIN];
  logic [WIN-1:0]  s1_fwd [WIN];
  wmsc_pkg::tmpl_t s1_fwd_data;
  logic [SB-1:0]   s1_slot [WIN];
  logic [BB-1:0]   s1_bank [WIN];
  logic            s1_end;
  wmsc_pkg::tmpl_t grid [WIN][WIN];
  logic [KB-1:0]   cost_k [WIN][WIN];

  // Stage 2.
  logic [KB-1:0] s2_cost [WIN][WIN];
  logic          s2_center, s2_end;
  logic [KB-1:0] s2_prior;
  logic [KB-1:0] colmin [WIN];

  // Stage 3.
  logic [KB-1:0] s3_colmin [WIN];
  logic          s3_center, s3_end;
  logic [KB-1:0] s3_prior;
  logic [KB-1:0] best, final_cost;

  logic [KB-1:0] o_cost;
  logic          o_end;

  // Configuration decode.
  always_comb begin
    hraw = {2'b00, cfg.data[wmsc_pkg::HRAW_BITS-1:0]};
    if (hraw == 13'd0) begin
      h_next = HB'(1);
    end else if (hraw > 13'(MAX_HEIGHT)) begin
      h_next = HB'(MAX_HEIGHT);
    end else begin
      h_next = HB'(hraw);
    end
    if (cfg.data == '0) begin
      w_next = WB'(1);
    end else if (cfg.data > WB'(wmsc_pkg::MAX_WIDTH)) begin
      w_next = WB'(wmsc_pkg::MAX_WIDTH);
    end else begin
      w_next = cfg.data;
    end
    dly_next = NB'({h_next, 1'b0})
             + ((h_next > HB'(2)) ? NB'(2) : NB'(h_next - HB'(1)));
  end

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid;
  assign cfg_hit   = cfg_acc && (cfg.index == wmsc_pkg::REG_FRAME_HEIGHT
                               || cfg.index == wmsc_pkg::REG_FRAME_WIDTH);

  // Item decode.
  assign acc        = pixels.valid && pixels.ready;
  assign is_write   = acc && pixels.op == wmsc_pkg::OP_PIXEL && !frame_received;
  assign pend_after = pend + NB'(is_write);
  assign emit       = acc && (is_write ? (pend_after > dly) : (pend != '0));
  assign in_last    = (HB'(irow) == h - HB'(1)) && ({1'b0, icol} == w - WB'(1));
  assign out_last   = (HB'(y) == h - HB'(1)) && ({1'b0, x} == w - WB'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= HB'(RESET_H);
      w <= WB'(1024);
      dly <= NB'(RESET_DLY);
      irow <= '0; imod <= '0; idiv <= '0; icol <= '0; islot <= '0;
      y <= '0; ymod <= '0; ydiv <= '0; x <= '0; xs <= '0;
      frame_received <= 1'b0;
      pend <= '0;
      wrp <= '0;
      rdp <= '0;
    end else if (cfg_hit) begin
      if (cfg.index == wmsc_pkg::REG_FRAME_HEIGHT) begin
        h <= h_next;
        dly <= dly_next;
      end else begin
        w <= w_next;
      end
      irow <= '0; imod <= '0; idiv <= '0; icol <= '0; islot <= '0;
      y <= '0; ymod <= '0; ydiv <= '0; x <= '0; xs <= '0;
      frame_received <= 1'b0;
      pend <= '0;
      rdp <= wrp;
    end else begin
      if (is_write) begin
        wrp <= (wrp == PB'(RDEPTH - 1)) ? '0 : wrp + PB'(1);
        if (in_last) begin
          frame_received <= 1'b1;
        end else if (HB'(irow) == h - HB'(1)) begin
          irow <= '0; imod <= '0; idiv <= '0;
          icol <= icol + CB'(1);
          islot <= (islot == SB'(TS - 1)) ? '0 : islot + SB'(1);
        end else begin
          irow <= irow + RB'(1);
          if (imod == BB'(WIN - 1)) begin
            imod <= '0;
            idiv <= idiv + AB'(1);
          end else begin
            imod <= imod + BB'(1);
          end
        end
      end
      if (emit) begin
        rdp <= (rdp == PB'(RDEPTH - 1)) ? '0 : rdp + PB'(1);
        if (out_last) begin
          irow <= '0; imod <= '0; idiv <= '0; icol <= '0; islot <= '0;
          y <= '0; ymod <= '0; ydiv <= '0; x <= '0; xs <= '0;
          frame_received <= 1'b0;
        end else if (HB'(y) == h - HB'(1)) begin
          y <= '0; ymod <= '0; ydiv <= '0;
          x <= x + CB'(1);
          xs <= (xs == SB'(TS - 1)) ? '0 : xs + SB'(1);
        end else begin
          y <= y + RB'(1);
          if (ymod == BB'(WIN - 1)) begin
            ymod <= '0;
            ydiv <= ydiv + AB'(1);
          end else begin
            ymod <= ymod + BB'(1);
          end
        end
      end
      pend <= pend_after - NB'(emit);
    end
  end

  // Reference delay line.
  always_ff @(posedge clk) begin
    if (is_write) begin
      rmem[wrp] <= '{ok: pixels.ref_valid,
                     pix: '{red: pixels.ref_red, green: pixels.ref_green,
                            blue: pixels.ref_blue},
                     prior: pixels.prior_cost};
    end
    if (emit) begin
      ref_rd <= rmem[rdp];
    end
  end

  // Template store write and window read.
  assign tw.en   = is_write;
  assign tw.slot = islot;
  assign tw.bank = imod;
  assign tw_data = '{ok: pixels.tmpl_valid,
                     pix: '{red: pixels.tmpl_red, green: pixels.tmpl_green,
                            blue: pixels.tmpl_blue}};

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      rsum = 4'(ymod) + 4'(k);
      bsum = rsum + 4'(WIN - wmsc_pkg::WIN_R);
      if (bsum >= 4'(2 * WIN)) begin
        bank_k[k] = BB'(bsum - 4'(2 * WIN));
      end else if (bsum >= 4'(WIN)) begin
        bank_k[k] = BB'(bsum - 4'(WIN));
      end else begin
        bank_k[k] = BB'(bsum);
      end
      if (rsum < 4'(wmsc_pkg::WIN_R)) begin
        addr_k[k] = ydiv - AB'(1);
      end else if (rsum >= 4'(WIN + wmsc_pkg::WIN_R)) begin
        addr_k[k] = ydiv + AB'(1);
      end else begin
        addr_k[k] = ydiv;
      end
    end
    for (int b = 0; b < WIN; b++) begin
      rd_addr[b] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (bank_k[k] == BB'(b)) begin
          rd_addr[b] = addr_k[k];
        end
      end
    end
    for (int j = 0; j < WIN; j++) begin
      ssum = 4'(xs) + 4'(j) + 4'(TS - wmsc_pkg::WIN_R);
      if (ssum >= 4'(2 * TS)) begin
        slot_j[j] = SB'(ssum - 4'(2 * TS));
      end else if (ssum >= 4'(TS)) begin
        slot_j[j] = SB'(ssum - 4'(TS));
      end else begin
        slot_j[j] = SB'(ssum);
      end
    end
  end

  // Clipping, received check and same-cycle write forwarding.
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      if (j <= wmsc_pkg::WIN_R) begin
        hterm = '0;
      end else begin
        hterm = (NB + 2)'(h) * (NB + 2)'(j - wmsc_pkg::WIN_R);
      end
      for (int k = 0; k < WIN; k++) begin
        ok_k[j][k] = 1'b1;
        if (j < wmsc_pkg::WIN_R && x < CB'(wmsc_pkg::WIN_R - j)) begin
          ok_k[j][k] = 1'b0;
        end
        if (j > wmsc_pkg::WIN_R
            && WB'(x) + WB'(j - wmsc_pkg::WIN_R) >= w) begin
          ok_k[j][k] = 1'b0;
        end
        if (k < wmsc_pkg::WIN_R && y < RB'(wmsc_pkg::WIN_R - k)) begin
          ok_k[j][k] = 1'b0;
        end
        if (k > wmsc_pkg::WIN_R
            && (HB + 1)'(y) + (HB + 1)'(k - wmsc_pkg::WIN_R) >= (HB + 1)'(h)) begin
          ok_k[j][k] = 1'b0;
        end
        if (j >= wmsc_pkg::WIN_R
            && hterm + (NB + 2)'(k)
               >= (NB + 2)'(pend_after) + (NB + 2)'(wmsc_pkg::WIN_R)) begin
          ok_k[j][k] = 1'b0;
        end
        fwd_k[j][k] = is_write && slot_j[j] == islot
                   && (RB + 2)'(y) + (RB + 2)'(k)
                      == (RB + 2)'(irow) + (RB + 2)'(wmsc_pkg::WIN_R);
      end
    end
  end

  wmsc_tmpl_store #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk     (clk),
    .wr      (tw),
    .wr_addr (idiv),
    .wr_data (tw_data),
    .rd_en   (emit),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // Handshake chain.
  assign o_adv    = !o_valid || results.ready;
  assign s3_ready = !s3_valid || o_adv;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign pixels.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= emit;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (o_adv) begin
        o_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_ok <= ok_k;
      s1_fwd <= fwd_k;
      s1_fwd_data <= tw_data;
      s1_slot <= slot_j;
      s1_bank <= bank_k;
      s1_end <= out_last;
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      for (int k = 0; k < WIN; k++) begin
        grid[j][k] = s1_fwd[j][k] ? s1_fwd_data : rdata[s1_slot[j]][s1_bank[k]];
        cost_k[j][k] = (s1_ok[j][k] && grid[j][k].ok)
                     ? wmsc_pkg::sad(ref_rd.pix, grid[j][k].pix) : wmsc_pkg::NO_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_cost <= cost_k;
      s2_center <= ref_rd.ok && grid[wmsc_pkg::WIN_R][wmsc_pkg::WIN_R].ok;
      s2_prior <= ref_rd.prior;
      s2_end <= s1_end;
    end
  end

  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      colmin[j] = wmsc_pkg::NO_MATCH;
      for (int k = 0; k < WIN; k++) begin
        if (s2_cost[j][k] < colmin[j]) begin
          colmin[j] = s2_cost[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_colmin <= colmin;
      s3_center <= s2_center;
      s3_prior <= s2_prior;
      s3_end <= s2_end;
    end
  end

  always_comb begin
    best = wmsc_pkg::NO_MATCH;
    for (int j = 0; j < WIN; j++) begin
      if (s3_colmin[j] < best) begin
        best = s3_colmin[j];
      end
    end
    if (!s3_center) begin
      final_cost = wmsc_pkg::NO_MATCH;
    end else if (s3_prior < best) begin
      final_cost = s3_prior;
    end else begin
      final_cost = best;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && o_adv) begin
      o_cost <= final_cost;
      o_end <= s3_end;
    end
  end

  assign results.valid     = o_valid;
  assign results.cost      = o_cost;
  assign results.frame_end = o_end;

  // A finished frame always has results left to drain.
  a_received_pending: assert property (@(posedge clk) disable iff (rst)
    frame_received |-> pend != '0)
    else $error("frame marked received with nothing pending");

  // Pending results never exceed the configured delay.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= dly)
    else $error("pending count exceeds delay");

  // Delay line occupancy matches the pending count.
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    ((wrp >= rdp) ? NB'(wrp - rdp) : NB'(wrp) + NB'(RDEPTH) - NB'(rdp)) == pend)
    else $error("delay line pointers disagree with pending count");

endmodule

`default_nettype wire
